FILE: rtl/core/wsru_pkg.sv
// Shared types and constants for the wavetable register unit.
`default_nettype none
package wsru_pkg;
	localparam int CHANNELS = 8;
	localparam int WAVE_BYTES = 128;
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int WA_W = $clog2(WAVE_BYTES);

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_SAMPLE = 2'd3
	} cmd_t;

	localparam logic [2:0] SUB_FREQ_LO = 3'd0;
	localparam logic [2:0] SUB_FREQ_HI = 3'd1;
	localparam logic [2:0] SUB_VOLUME  = 3'd2;
	localparam logic [2:0] SUB_OFFSET  = 3'd3;

	// Per-channel control word kept in the channel memory.
	typedef struct packed {
		logic [11:0] freq;
		logic [3:0]  len;
		logic [3:0]  vol;
		logic [6:0]  offs;
		logic        en;
		logic [31:0] phase;
	} chan_t;

	// Divider handshake between top level and divider.
	typedef struct packed {
		logic        start;
		logic [19:0] num;
		logic [4:0]  den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [19:0] quo;
		logic [3:0]  rem;
	} div_rsp_t;
endpackage
`default_nettype wire

FILE: rtl/core/wavetable_synth_register_unit.sv
// Wavetable register unit: one command per transfer, one result per command. A write or a
// channel read passes through ST_BUS_RD, ST_BUS_DO and ST_FINISH before the registered result
// strobe; a wave read adds ST_WAVE_RD. A tick first counts the enabled channels, then visits
// every channel, enabled or not (read, a 20-step serial divide of the scaled frequency by the
// active count, phase update of an enabled channel). A sample request visits every channel,
// where a 20-step serial remainder wraps the phase over the wave length.
// busy is high from the accepting edge until the result strobe; the receiver cannot stall.
// Reset clears the wave and channel memories with a sweep over all wave addresses, during
// which busy stays high.
`default_nettype none
module wavetable_synth_register_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  cmd,
	input  wire logic [15:0] bus_address,
	input  wire logic [7:0]  write_data,
	input  wire logic [9:0]  tick_cycles,
	output logic             done,
	output logic [7:0]       read_data,
	output logic [6:0]       mix_sum
);
	import wsru_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_BUS_RD, ST_BUS_DO, ST_WAVE_RD, ST_FINISH,
		ST_CNT_RD, ST_CNT_ACC, ST_T_RD, ST_T_DIV, ST_T_WAIT, ST_T_MUL,
		ST_S_RD, ST_S_DIV, ST_S_WAIT, ST_S_WAVE
	} state_t;

	state_t state_q;

	// Memories: wave bytes and channel words, with registered reads.
	logic [7:0] wave_mem [WAVE_BYTES];
	chan_t      chan_mem [CHANNELS];

	logic            wave_we;
	logic [WA_W-1:0] wave_wa;
	logic [7:0]      wave_wd;
	logic [WA_W-1:0] wave_ra;
	logic [7:0]      wave_rd;
	logic            chan_we;
	logic [CH_W-1:0] chan_wa;
	chan_t           chan_wd;
	logic [CH_W-1:0] chan_ra;
	chan_t           chan_rd;

	always_ff @(posedge clk) begin
		if (wave_we) wave_mem[wave_wa] <= wave_wd;
		wave_rd <= wave_mem[wave_ra];
		if (chan_we) chan_mem[chan_wa] <= chan_wd;
		chan_rd <= chan_mem[chan_ra];
	end

	// Captured item.
	cmd_t        cmd_q;
	logic [15:0] addr_q;
	logic [7:0]  data_q;
	logic [9:0]  n_q;
	logic [7:0]  ptr_q;
	logic [WA_W:0] clr_q;
	logic [CH_W:0] ch_q;
	logic [3:0]  active_q;
	logic [6:0]  mix_q;
	chan_t       cur_q;
	logic [6:0]  p_q;
	logic [19:0] step_q;
	logic [7:0]  rd_q;
	logic        done_q;
	logic [6:0]  mixo_q;

	div_req_t dreq;
	div_rsp_t drsp;
	wsru_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// Address decode on the captured address.
	logic        is_wave, is_chan, is_ptr, ch_ok;
	logic [CH_W-1:0] a_ch;
	logic [2:0]  a_sub;
	logic [7:0]  a_chfull;
	assign is_wave  = (addr_q >= 16'h4800) && (addr_q < 16'h5000);
	assign is_chan  = (addr_q >= 16'h5000) && (addr_q < 16'h5800);
	assign is_ptr   = (addr_q & 16'hF801) == 16'hF800;
	assign a_chfull = addr_q[10:3];
	assign ch_ok    = a_chfull < 8'(CHANNELS);
	assign a_ch     = a_chfull[CH_W-1:0];
	assign a_sub    = addr_q[2:0];

	// Sample path helpers.
	logic [3:0]  nib;
	logic [7:0]  prod;
	logic [15:0] recip;
	logic [3:0]  chout;

	// Divide by 15 as a multiply by 137/2048, exact for products up to 225.
	always_comb begin
		nib   = p_q[0] ? wave_rd[7:4] : wave_rd[3:0];
		prod  = {4'b0, nib} * {4'b0, cur_q.vol};
		recip = {8'b0, prod} * 16'd137;
		chout = recip[14:11];
	end

	// Tick phase step: N times the divided frequency, at most 30 bits.
	logic [29:0] step_prod;
	logic [31:0] phase_new;
	assign step_prod = {10'd0, step_q} * {20'd0, n_q};
	assign phase_new = cur_q.phase + {2'b0, step_prod};

	// Bus read mux.
	logic [7:0] bus_rd;
	always_comb begin
		bus_rd = '0;
		if (is_chan && ch_ok) begin
			case (a_sub)
				SUB_FREQ_LO: bus_rd = chan_rd.freq[7:0];
				SUB_FREQ_HI: bus_rd = {chan_rd.len, chan_rd.freq[11:8]};
				SUB_VOLUME:  bus_rd = {4'b0, chan_rd.vol};
				SUB_OFFSET:  bus_rd = {chan_rd.en, chan_rd.offs & 7'h60};
				default:     bus_rd = '0;
			endcase
		end
	end

	// Memory port control.
	always_comb begin
		wave_we = 1'b0;
		wave_wa = ptr_q[WA_W-1:0];
		wave_wd = data_q;
		wave_ra = ptr_q[WA_W-1:0];
		chan_we = 1'b0;
		chan_wa = ch_q[CH_W-1:0];
		chan_wd = cur_q;
		chan_ra = ch_q[CH_W-1:0];
		dreq.start = 1'b0;
		dreq.num = {chan_rd.freq, 8'h00};
		dreq.den = {1'b0, active_q};
		case (state_q)
			ST_CLEAR: begin
				wave_we = 1'b1;
				wave_wa = clr_q[WA_W-1:0];
				wave_wd = '0;
				chan_we = clr_q < (WA_W+1)'(CHANNELS);
				chan_wa = clr_q[CH_W-1:0];
				chan_wd = '0;
			end
			ST_IDLE: chan_ra = a_ch;
			ST_BUS_RD: chan_ra = a_ch;
			ST_BUS_DO: begin
				chan_wa = a_ch;
				if (cmd_q == CMD_WRITE && is_wave) wave_we = 1'b1;
				if (cmd_q == CMD_WRITE && is_chan && ch_ok) begin
					chan_we = 1'b1;
					chan_wd = chan_rd;
					case (a_sub)
						SUB_FREQ_LO: chan_wd.freq[7:0] = data_q;
						SUB_FREQ_HI: begin
							chan_wd.freq[11:8] = data_q[3:0];
							chan_wd.len = data_q[7:4];
						end
						SUB_VOLUME: chan_wd.vol = data_q[3:0];
						SUB_OFFSET: begin
							chan_wd.offs = data_q[6:0] & 7'h60;
							chan_wd.en = data_q[7];
						end
						default: chan_we = 1'b0;
					endcase
				end
			end
			ST_T_DIV: dreq.start = 1'b1;
			ST_T_MUL: begin
				chan_we = cur_q.en;
				chan_wd.phase = phase_new;
			end
			// Nibble index wraps over (length + 1) * 8: divide phase >> 19 by length + 1.
			ST_S_DIV: begin
				dreq.start = 1'b1;
				dreq.num = {7'd0, chan_rd.phase[31:19]};
				dreq.den = {1'b0, chan_rd.len} + 5'd1;
			end
			ST_S_WAVE: wave_ra = cur_q.offs + {1'b0, p_q[6:1]};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			ptr_q   <= '0;
			done_q  <= 1'b0;
			rd_q    <= '0;
			mixo_q  <= '0;
			ch_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (WA_W+1)'(WAVE_BYTES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (start) begin
					cmd_q  <= cmd_t'(cmd);
					addr_q <= bus_address;
					data_q <= write_data;
					n_q    <= tick_cycles;
					ch_q   <= '0;
					active_q <= '0;
					mix_q  <= '0;
					case (cmd_t'(cmd))
						CMD_WRITE, CMD_READ: state_q <= ST_BUS_RD;
						CMD_TICK: state_q <= ST_CNT_RD;
						default: state_q <= ST_S_RD;
					endcase
				end
				ST_BUS_RD: state_q <= ST_BUS_DO;
				ST_BUS_DO: begin
					rd_q <= '0;
					if (cmd_q == CMD_WRITE) begin
						if (is_wave && ptr_q[7])
							ptr_q <= {1'b1, ptr_q[6:0] + 7'd1};
						else if (is_ptr)
							ptr_q <= data_q;
						state_q <= ST_FINISH;
					end else if (is_wave) begin
						state_q <= ST_WAVE_RD;
					end else begin
						rd_q <= bus_rd;
						state_q <= ST_FINISH;
					end
				end
				// Wave byte is back: finish a read, or accumulate one sample channel.
				ST_WAVE_RD: begin
					if (cmd_q == CMD_SAMPLE) begin
						if (cur_q.en) mix_q <= mix_q + {3'b0, chout};
						if (ch_q == (CH_W+1)'(CHANNELS - 1)) begin
							state_q <= ST_FINISH;
						end else begin
							ch_q <= ch_q + 1'b1;
							state_q <= ST_S_RD;
						end
					end else begin
						rd_q <= wave_rd;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					done_q <= 1'b1;
					mixo_q <= (cmd_q == CMD_SAMPLE) ? mix_q : 7'd0;
					if (cmd_q != CMD_READ) rd_q <= '0;
					state_q <= ST_IDLE;
				end
				// Tick: count enabled channels first.
				ST_CNT_RD: state_q <= ST_CNT_ACC;
				ST_CNT_ACC: begin
					active_q <= active_q + 4'(chan_rd.en);
					if (ch_q == (CH_W+1)'(CHANNELS - 1)) begin
						ch_q <= '0;
						state_q <= ST_T_RD;
					end else begin
						ch_q <= ch_q + 1'b1;
						state_q <= ST_CNT_RD;
					end
				end
				ST_T_RD: begin
					if (active_q == 4'd0) active_q <= 4'd1;
					state_q <= ST_T_DIV;
				end
				ST_T_DIV: begin
					cur_q <= chan_rd;
					state_q <= ST_T_WAIT;
				end
				ST_T_WAIT: if (drsp.done) begin
					step_q <= drsp.quo;
					state_q <= ST_T_MUL;
				end
				ST_T_MUL: begin
					if (ch_q == (CH_W+1)'(CHANNELS - 1)) begin
						state_q <= ST_FINISH;
					end else begin
						ch_q <= ch_q + 1'b1;
						state_q <= ST_T_RD;
					end
				end
				// Sample: read channel word, wrap the phase, then read the wave byte.
				ST_S_RD: state_q <= ST_S_DIV;
				ST_S_DIV: begin
					cur_q <= chan_rd;
					state_q <= ST_S_WAIT;
				end
				ST_S_WAIT: if (drsp.done) begin
					p_q <= {drsp.rem, cur_q.phase[18:16]};
					state_q <= ST_S_WAVE;
				end
				ST_S_WAVE: state_q <= ST_WAVE_RD;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy      = state_q != ST_IDLE;
	assign done      = done_q;
	assign read_data = rd_q;
	assign mix_sum   = mixo_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy);
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done);
	a_mix_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> mix_sum <= 7'd120);
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (read_data == 8'd0 || mix_sum == 7'd0));
endmodule
`default_nettype wire

FILE: rtl/core/wsru_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module wsru_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wsru_pkg::div_req_t     req,
	output wsru_pkg::div_rsp_t     rsp
);
	import wsru_pkg::*;

	logic [19:0] num_q;
	logic [19:0] quo_q;
	logic [3:0]  rem_q;
	logic [4:0]  den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [4:0]  trial;
	logic [4:0]  diff;

	// Divisor is at most 16, so the remainder always fits in four bits.
	assign trial = {rem_q, num_q[19]};
	assign diff  = trial - den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd20;
				num_q  <= req.num;
				den_q  <= req.den;
				rem_q  <= '0;
				quo_q  <= '0;
			end else if (busy_q) begin
				num_q <= {num_q[18:0], 1'b0};
				if (trial >= den_q) begin
					rem_q <= diff[3:0];
					quo_q <= {quo_q[18:0], 1'b1};
				end else begin
					rem_q <= trial[3:0];
					quo_q <= {quo_q[18:0], 1'b0};
				end
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;
endmodule
`default_nettype wire

FILE: tb/sv/wavetable_synth_register_unit_tb.sv
// Self-checking testbench for the wavetable synth register unit.
`default_nettype none
module wavetable_synth_register_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wsru_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int RAND_ITEMS = 700;

	typedef struct {
		cmd_t        op;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [9:0]  ticks;
		bit          known;
		logic [7:0]  rd;
		logic [6:0]  mix;
	} stim_row_t;

	typedef struct {
		logic [7:0] rd;
		logic [6:0] mix;
	} bus_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [15:0] bus_address;
	logic [7:0]  write_data;
	logic [9:0]  tick_cycles;
	logic        done;
	logic [7:0]  read_data;
	logic [6:0]  mix_sum;

	// predictor copy of the block's state
	logic [7:0]  pred_wave [WAVE_BYTES];
	logic [7:0]  wave_ptr;
	logic [11:0] ch_freq [CHANNELS];
	logic [3:0]  ch_len [CHANNELS];
	logic [3:0]  ch_vol [CHANNELS];
	logic [6:0]  ch_offs [CHANNELS];
	logic        ch_en [CHANNELS];
	logic [31:0] ch_phase [CHANNELS];

	bus_result_t pending_results[$];
	int          errors = 0;
	int          results_seen = 0;
	int          n_sent = 0;
	int          n_ticks = 0;
	int          n_samples = 0;
	int          cycles = 0;

	wavetable_synth_register_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .bus_address(bus_address), .write_data(write_data),
		.tick_cycles(tick_cycles), .done(done), .read_data(read_data),
		.mix_sum(mix_sum)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic reset_state();
		for (int i = 0; i < WAVE_BYTES; i++) pred_wave[i] = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			ch_freq[i] = '0; ch_len[i] = '0; ch_vol[i] = '0;
			ch_offs[i] = '0; ch_en[i] = 1'b0; ch_phase[i] = '0;
		end
		wave_ptr = '0;
	endtask

	task automatic apply_command(input cmd_t op, input logic [15:0] a, input logic [7:0] d,
			input logic [9:0] n, output logic [7:0] rd, output logic [6:0] mix);
		int          ch;
		logic [2:0]  sub;
		int          active;
		logic [31:0] step, len, p;
		logic [7:0]  b;
		logic [3:0]  nib;
		int          acc;
		rd = '0;
		mix = '0;
		ch = (int'(a) - 'h5000) / 8;
		sub = a[2:0];
		case (op)
			CMD_WRITE: begin
				if (a >= 16'h4800 && a < 16'h5000) begin
					pred_wave[wave_ptr[6:0]] = d;
					if (wave_ptr[7]) wave_ptr = {1'b1, wave_ptr[6:0] + 7'd1};
				end else if (a >= 16'h5000 && a < 16'h5800) begin
					if (ch < CHANNELS) begin
						case (sub)
							SUB_FREQ_LO: ch_freq[ch][7:0] = d;
							SUB_FREQ_HI: begin
								ch_freq[ch][11:8] = d[3:0];
								ch_len[ch] = d[7:4];
							end
							SUB_VOLUME: ch_vol[ch] = d[3:0];
							SUB_OFFSET: begin
								ch_offs[ch] = {1'b0, d[6:5], 5'd0};
								ch_en[ch] = d[7];
							end
							default: ;
						endcase
					end
				end else if ((a & 16'hF801) == 16'hF800) begin
					wave_ptr = d;
				end
			end
			CMD_READ: begin
				if (a >= 16'h4800 && a < 16'h5000) begin
					rd = pred_wave[wave_ptr[6:0]];
				end else if (a >= 16'h5000 && a < 16'h5800 && ch < CHANNELS) begin
					case (sub)
						SUB_FREQ_LO: rd = ch_freq[ch][7:0];
						SUB_FREQ_HI: rd = {ch_len[ch], ch_freq[ch][11:8]};
						SUB_VOLUME:  rd = {4'd0, ch_vol[ch]};
						SUB_OFFSET:  rd = {ch_en[ch], ch_offs[ch][6:5], 5'd0};
						default:     rd = '0;
					endcase
				end
			end
			CMD_TICK: begin
				active = 0;
				for (int i = 0; i < CHANNELS; i++) if (ch_en[i]) active++;
				if (active == 0) active = 1;
				for (int i = 0; i < CHANNELS; i++) begin
					if (ch_en[i]) begin
						step = ({20'd0, ch_freq[i]} << 8) / active;
						ch_phase[i] = ch_phase[i] + n * step;
					end
				end
			end
			default: begin
				acc = 0;
				for (int i = 0; i < CHANNELS; i++) begin
					if (ch_en[i]) begin
						len = (ch_len[i] + 32'd1) * 32'd8;
						p = (ch_phase[i] >> 16) % len;
						b = pred_wave[(ch_offs[i] + (p >> 1)) & 32'h7F];
						nib = p[0] ? b[7:4] : b[3:0];
						acc += (nib * ch_vol[i]) / 15;
					end
				end
				mix = acc[6:0];
			end
		endcase
	endtask

	// one transfer: optional gap, then hold start until the block takes it
	task automatic send_item(input stim_row_t row, input int gap);
		bus_result_t r;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= row.op;
		bus_address <= row.addr;
		write_data <= row.data;
		tick_cycles <= row.ticks;
		do @(posedge clk); while (busy);
		apply_command(row.op, row.addr, row.data, row.ticks, r.rd, r.mix);
		if (row.known) begin
			r.rd = row.rd;
			r.mix = row.mix;
		end
		pending_results.push_back(r);
		n_sent++;
		if (row.op == CMD_TICK) n_ticks++;
		if (row.op == CMD_SAMPLE) n_samples++;
	endtask

	function automatic stim_row_t mk(cmd_t op, logic [15:0] a, logic [7:0] d, logic [9:0] n,
			bit known = 0, logic [7:0] rd = 0, logic [6:0] mix = 0);
		stim_row_t s;
		s.op = op; s.addr = a; s.data = d; s.ticks = n;
		s.known = known; s.rd = rd; s.mix = mix;
		return s;
	endfunction

	function automatic stim_row_t random_row();
		int          pick;
		logic [15:0] a;
		cmd_t        op;
		pick = $urandom_range(0, 99);
		a = 16'(16'h5000 | ($urandom_range(0, 7) << 3) | $urandom_range(0, 3));
		if (pick < 30) op = CMD_WRITE;
		else if (pick < 50) op = CMD_READ;
		else if (pick < 70) op = CMD_TICK;
		else op = CMD_SAMPLE;
		case ($urandom_range(0, 9))
			0, 1: a = 16'(16'h4800 | $urandom_range(0, 16'h7FF));
			2:    a = 16'(16'hF800 | ($urandom_range(0, 16'h3FF) << 1));
			3:    a = 16'($urandom_range(0, 16'hFFFF));
			4:    a = 16'(16'h5000 | $urandom_range(0, 16'h7FF));
			default: ;
		endcase
		return mk(op, a, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
	endfunction

	always @(posedge clk) begin
		bus_result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result rd=%h mix=%0d", $time, read_data, mix_sum);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (read_data !== want.rd) begin
					$display("%0t: read_data expected %h actual %h", $time, want.rd, read_data);
					errors++;
				end
				if (mix_sum !== want.mix) begin
					$display("%0t: mix_sum expected %0d actual %0d", $time, want.mix, mix_sum);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		stim_row_t dir_rows[$];
		int        gap;
		bit        burst;
		int        settle;
		start = 1'b0;
		cmd = CMD_WRITE;
		bus_address = '0;
		write_data = '0;
		tick_cycles = '0;
		arst_n = 1'b0;
		burst = 0;
		reset_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		dir_rows.push_back(mk(CMD_READ,   16'h4800, 8'h00, 10'd0, 1, 8'h00, 7'd0));
		dir_rows.push_back(mk(CMD_SAMPLE, 16'h0000, 8'h00, 10'd0, 1, 8'h00, 7'd0));
		dir_rows.push_back(mk(CMD_READ,   16'h5003, 8'hFF, 10'd0, 1, 8'h00, 7'd0));
		dir_rows.push_back(mk(CMD_WRITE,  16'hF800, 8'h80, 10'd0));
		dir_rows.push_back(mk(CMD_WRITE,  16'h4800, 8'hFF, 10'd0));
		dir_rows.push_back(mk(CMD_WRITE,  16'h4FFF, 8'h12, 10'd0));
		dir_rows.push_back(mk(CMD_WRITE,  16'hF801, 8'h00, 10'd0));
		dir_rows.push_back(mk(CMD_READ,   16'h0000, 8'h00, 10'd0, 1, 8'h00, 7'd0));
		dir_rows.push_back(mk(CMD_READ,   16'hFFFF, 8'hFF, 10'h3FF, 1, 8'h00, 7'd0));
		dir_rows.push_back(mk(CMD_WRITE,  16'h5000, 8'hFF, 10'd0));
		dir_rows.push_back(mk(CMD_WRITE,  16'h5001, 8'hF7, 10'd0));
		dir_rows.push_back(mk(CMD_WRITE,  16'h5002, 8'h0F, 10'd0));
		dir_rows.push_back(mk(CMD_WRITE,  16'h5003, 8'hFF, 10'd0));
		dir_rows.push_back(mk(CMD_READ,   16'h5001, 8'h00, 10'd0, 1, 8'hF7, 7'd0));
		dir_rows.push_back(mk(CMD_READ,   16'h5003, 8'h00, 10'd0, 1, 8'hE0, 7'd0));
		dir_rows.push_back(mk(CMD_WRITE,  16'h503B, 8'h80, 10'd0));
		dir_rows.push_back(mk(CMD_WRITE,  16'h5042, 8'h0F, 10'd0));
		dir_rows.push_back(mk(CMD_READ,   16'h5042, 8'h00, 10'd0, 1, 8'h00, 7'd0));
		dir_rows.push_back(mk(CMD_WRITE,  16'h5005, 8'hFF, 10'd0));
		dir_rows.push_back(mk(CMD_READ,   16'h5005, 8'h00, 10'd0, 1, 8'h00, 7'd0));
		dir_rows.push_back(mk(CMD_TICK,   16'h0000, 8'h00, 10'd0));
		dir_rows.push_back(mk(CMD_SAMPLE, 16'h0000, 8'h00, 10'd0));
		dir_rows.push_back(mk(CMD_TICK,   16'hFFFF, 8'hFF, 10'h3FF));
		dir_rows.push_back(mk(CMD_SAMPLE, 16'hFFFF, 8'hFF, 10'h3FF));
		dir_rows.push_back(mk(CMD_READ,   16'h4FFF, 8'h00, 10'd0));
		foreach (dir_rows[i]) send_item(dir_rows[i], $urandom_range(0, 18));

		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 60 == 0) burst = ($urandom_range(0, 2) == 0);
			// let the block drain completely before this transfer
			if (i == RAND_ITEMS / 2) begin
				start <= 1'b0;
				wait (pending_results.size() == 0);
			end
			gap = burst ? 0 : $urandom_range(0, 18);
			send_item(random_row(), gap);
		end
		start <= 1'b0;

		wait (pending_results.size() == 0);
		settle = 0;
		while (settle < 300) begin
			@(posedge clk);
			settle++;
		end
		$display("sent %0d items (%0d ticks, %0d samples), checked %0d results",
			n_sent, n_ticks, n_samples, results_seen);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
`default_nettype wire
